### rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. They compile to nothing under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/core/rcsp_pkg.sv
`timescale 1ns / 1ps

package rcsp_pkg;

  localparam int NUM_CHANNELS = 7;
  localparam int CHAN_W       = 3;
  localparam int OUT_W        = 16;
  localparam int BUTTON_W     = 8;
  localparam int IDLE_W       = 32;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHAR_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;  // '-'
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;  // newline

  localparam logic [IDLE_W-1:0]  TIMEOUT_RESET = 32'd1000;
  localparam logic [CHAN_W-1:0]  NO_CHANNEL    = 3'd7;

  typedef struct packed {
    logic              kind;           // 1 = millisecond tick
    logic [7:0]        char_byte;
    logic [CHAN_W-1:0] query_channel;
    logic [7:0]        button_mask;
  } item_t;

  typedef struct packed {
    logic [OUT_W-1:0]    query_value;
    logic [BUTTON_W-1:0] masked_buttons;
    logic                timed_out;
    logic                channel_written;
    logic [CHAN_W-1:0]   written_channel;
    logic [OUT_W-1:0]    written_value;
  } result_t;

  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] idx;
  } chan_sel_t;

  // Channel letters: x y z u v w a.
  function automatic chan_sel_t channel_of(input logic [7:0] c);
    chan_sel_t sel;
    sel = '{valid: 1'b1, idx: '0};
    unique case (c)
      8'h78:   sel.idx = 3'd0;
      8'h79:   sel.idx = 3'd1;
      8'h7A:   sel.idx = 3'd2;
      8'h75:   sel.idx = 3'd3;
      8'h76:   sel.idx = 3'd4;
      8'h77:   sel.idx = 3'd5;
      8'h61:   sel.idx = 3'd6;
      default: sel.valid = 1'b0;
    endcase
    return sel;
  endfunction

  // Button letters: L R U D X Y A B, lowest bit first.
  function automatic logic [BUTTON_W-1:0] button_of(input logic [7:0] c);
    logic [BUTTON_W-1:0] b;
    b = '0;
    unique case (c)
      8'h4C:   b = 8'h01;
      8'h52:   b = 8'h02;
      8'h55:   b = 8'h04;
      8'h44:   b = 8'h08;
      8'h58:   b = 8'h10;
      8'h59:   b = 8'h20;
      8'h41:   b = 8'h40;
      8'h42:   b = 8'h80;
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

### rtl/core/rcsp_parser.sv
`timescale 1ns / 1ps

module rcsp_parser #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             step,
  input  rcsp_pkg::item_t                  item,
  input  logic [rcsp_pkg::IDLE_W-1:0]      timeout_ticks,
  output rcsp_pkg::result_t                result
);

  logic [VALUE_WIDTH-1:0]              acc, acc_next;
  logic                                neg, neg_next;
  logic [7:0]                          last_letter, last_letter_next;
  logic [rcsp_pkg::BUTTON_W-1:0]       pending, pending_next;
  logic [rcsp_pkg::BUTTON_W-1:0]       committed, committed_next;
  logic [rcsp_pkg::IDLE_W-1:0]         idle_count, idle_count_next;
  logic [VALUE_WIDTH-1:0]              store [rcsp_pkg::NUM_CHANNELS];

  logic                                is_digit, is_minus, is_term;
  logic [3:0]                          digit;
  logic [7:0]                          digit_full;
  logic [VALUE_WIDTH-1:0]              acc_mul;
  logic [VALUE_WIDTH-1:0]              field_value;
  logic [VALUE_WIDTH-1:0]              query_raw;
  logic [VALUE_WIDTH+rcsp_pkg::OUT_W-1:0] query_ext, written_ext;
  rcsp_pkg::chan_sel_t                 sel;
  logic                                do_write;

  assign digit_full = item.char_byte - rcsp_pkg::CHAR_ZERO;
  assign digit      = digit_full[3:0];
  assign is_digit   = !item.kind && (item.char_byte >= rcsp_pkg::CHAR_ZERO)
                      && (item.char_byte <= rcsp_pkg::CHAR_NINE);
  assign is_minus   = !item.kind && (item.char_byte == rcsp_pkg::CHAR_MINUS);
  assign is_term    = !item.kind && !is_digit && !is_minus;

  // Times ten as two shifted copies, wrapping at the value width.
  assign acc_mul = {acc[VALUE_WIDTH-4:0], 3'b000} + {acc[VALUE_WIDTH-2:0], 1'b0}
                   + VALUE_WIDTH'(digit);
  assign field_value = neg ? (VALUE_WIDTH'(0) - acc) : acc;
  assign sel         = rcsp_pkg::channel_of(last_letter);
  assign do_write    = is_term && sel.valid;

  always_comb begin
    acc_next         = acc;
    neg_next         = neg;
    last_letter_next = last_letter;
    pending_next     = pending;
    committed_next   = committed;
    if (item.kind) begin
      idle_count_next = (&idle_count) ? idle_count : idle_count + 1'b1;
    end else begin
      idle_count_next = '0;
    end
    if (is_digit) begin
      acc_next = acc_mul;
    end else if (is_minus) begin
      neg_next = 1'b1;
    end else if (is_term) begin
      acc_next         = '0;
      neg_next         = 1'b0;
      last_letter_next = item.char_byte;
      if (item.char_byte == rcsp_pkg::CHAR_NEWLINE) begin
        committed_next = pending;
        pending_next   = '0;
      end else begin
        pending_next = pending | rcsp_pkg::button_of(item.char_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= '0;
      neg         <= 1'b0;
      last_letter <= '0;
      pending     <= '0;
      committed   <= '0;
      idle_count  <= '0;
      for (int i = 0; i < rcsp_pkg::NUM_CHANNELS; i++) begin
        store[i] <= '0;
      end
    end else if (step) begin
      acc         <= acc_next;
      neg         <= neg_next;
      last_letter <= last_letter_next;
      pending     <= pending_next;
      committed   <= committed_next;
      idle_count  <= idle_count_next;
      for (int i = 0; i < rcsp_pkg::NUM_CHANNELS; i++) begin
        if (do_write && (sel.idx == rcsp_pkg::CHAN_W'(i))) begin
          store[i] <= field_value;
        end
      end
    end
  end

  // The query reports the store as it stands after this item, so a value
  // written now is forwarded.
  always_comb begin
    if (item.query_channel == rcsp_pkg::NO_CHANNEL) begin
      query_raw = '0;
    end else if (do_write && (sel.idx == item.query_channel)) begin
      query_raw = field_value;
    end else begin
      query_raw = store[item.query_channel];
    end
  end

  assign query_ext   = {{rcsp_pkg::OUT_W{1'b0}}, query_raw};
  assign written_ext = {{rcsp_pkg::OUT_W{1'b0}}, field_value};

  always_comb begin
    result.query_value     = query_ext[rcsp_pkg::OUT_W-1:0];
    result.masked_buttons  = committed_next & item.button_mask;
    result.timed_out       = idle_count_next > timeout_ticks;
    result.channel_written = do_write;
    result.written_channel = do_write ? sel.idx : '0;
    result.written_value   = do_write ? written_ext[rcsp_pkg::OUT_W-1:0] : '0;
  end

endmodule

### rtl/core/remote_control_stream_parser.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Remote control stream parser. Each input item is either a received character
// or a millisecond tick (tuser high). Digits build a number, '-' marks it
// negative, and any other character stores the number into the channel named
// by the previous letter and, for a button letter, sets a pending button bit
// that the next newline commits. Every item yields exactly one result item with
// the queried channel value, the masked committed buttons, the timeout status
// and, when a channel was stored, its index and value (tuser high). The block
// takes one item per cycle when the receiver does not stall the output; each
// item passes the input register, then the parser update, then the result
// register. The timeout register resets to 1000 ticks; the user must write it
// with cfg_we while the block is idle, as the block itself does not enforce it.
module remote_control_stream_parser #(
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] char_byte, [10:8] query_channel, [18:11] button_mask, rest zero
  input  logic [23:0] s_axis_tdata,
  // [0] kind
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] query_value, [23:16] masked_buttons, [24] timed_out,
  // [27:25] written_channel, [43:28] written_value, rest zero
  output logic [47:0] m_axis_tdata,
  // [0] channel_written
  output logic        m_axis_tuser
);

  logic                             in_v, out_v, advance;
  rcsp_pkg::item_t                  item_q;
  rcsp_pkg::result_t                result, res_q;
  logic [rcsp_pkg::IDLE_W-1:0]      timeout_ticks;

  assign advance       = in_v && (!out_v || m_axis_tready);
  assign s_axis_tready = !in_v || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= rcsp_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_v <= 1'b1;
    end else if (advance) begin
      in_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q.kind          <= s_axis_tuser;
      item_q.char_byte     <= s_axis_tdata[7:0];
      item_q.query_channel <= s_axis_tdata[10:8];
      item_q.button_mask   <= s_axis_tdata[18:11];
    end
  end

  rcsp_parser #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_parser (
    .clk           (clk),
    .rst           (rst),
    .step          (advance),
    .item          (item_q),
    .timeout_ticks (timeout_ticks),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (advance) begin
      out_v <= 1'b1;
    end else if (m_axis_tready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= result;
    end
  end

  assign m_axis_tvalid = out_v;
  assign m_axis_tuser  = res_q.channel_written;
  assign m_axis_tdata  = {4'b0000, res_q.written_value, res_q.written_channel,
                          res_q.timed_out, res_q.masked_buttons, res_q.query_value};

  `ASSERT_ALWAYS(a_ready_when_empty, clk, !in_v |-> s_axis_tready, "empty input stage not ready")
  `ASSERT_CLK(a_moves_to_empty_out, clk, rst, in_v && !out_v |=> out_v, "item did not advance")
  `ASSERT_CLK(a_no_write_fields_zero, clk, rst, out_v && !m_axis_tuser |-> m_axis_tdata[43:25] == 19'd0, "write fields set without a store")
  `ASSERT_CLK(a_write_channel_range, clk, rst, out_v && m_axis_tuser |-> m_axis_tdata[27:25] != 3'd7, "stored channel out of range")

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int VALUE_W = 16;

  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  localparam logic [7:0] LETTER_X = "x";
  localparam logic [7:0] LETTER_Y = "y";
  localparam logic [7:0] LETTER_Z = "z";
  localparam logic [7:0] LETTER_U = "u";
  localparam logic [7:0] LETTER_V = "v";
  localparam logic [7:0] LETTER_W = "w";
  localparam logic [7:0] LETTER_A = "a";
  localparam logic [7:0] LETTER_Q = "Q";
  localparam logic [7:0] CHAR_HASH = "#";

  localparam logic [7:0] KEY_L = "L";
  localparam logic [7:0] KEY_R = "R";
  localparam logic [7:0] KEY_U = "U";
  localparam logic [7:0] KEY_D = "D";
  localparam logic [7:0] KEY_X = "X";
  localparam logic [7:0] KEY_Y = "Y";
  localparam logic [7:0] KEY_A = "A";
  localparam logic [7:0] KEY_B = "B";

  localparam int     RANDOM_ITEMS  = 520;
  localparam int     RESET_TICKS   = 12;
  localparam int     LONG_HOLD     = 300;
  localparam int     SETTLE_CYCLES = 4;
  localparam int     DRAIN_LIMIT   = 100000;
  localparam longint RUN_LIMIT_NS  = 20_000_000;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic [31:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  // [7:0] char_byte, [10:8] query_channel, [18:11] button_mask, rest zero
  logic [23:0] s_axis_tdata;
  // [0] kind
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] query_value, [23:16] masked_buttons, [24] timed_out,
  // [27:25] written_channel, [43:28] written_value, rest zero
  logic [47:0] m_axis_tdata;
  // [0] channel_written
  logic        m_axis_tuser;

  remote_control_stream_parser #(.VALUE_WIDTH(VALUE_W)) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser state as the block should hold it.
  logic [VALUE_W-1:0] number_acc;
  logic               number_negative;
  logic [7:0]         prev_letter;
  logic [7:0]         buttons_pending;
  logic [7:0]         buttons_committed;
  logic [VALUE_W-1:0] channel_values [rcsp_pkg::NUM_CHANNELS];
  logic [31:0]        idle_ticks;
  logic [31:0]        timeout_limit;

  rcsp_pkg::result_t due_reports [$];

  int error_count = 0;
  int items_sent = 0;
  int chars_seen = 0;
  int ticks_seen = 0;
  int stores_seen = 0;
  int timeouts_seen = 0;

  bit sender_idles = 1'b1;
  bit receiver_stalls = 1'b1;
  bit hold_request = 1'b0;

  function automatic logic [7:0] channel_letter(input int i);
    case (i)
      0: return LETTER_X;
      1: return LETTER_Y;
      2: return LETTER_Z;
      3: return LETTER_U;
      4: return LETTER_V;
      5: return LETTER_W;
      default: return LETTER_A;
    endcase
  endfunction

  function automatic logic [7:0] button_letter(input int i);
    case (i)
      0: return KEY_L;
      1: return KEY_R;
      2: return KEY_U;
      3: return KEY_D;
      4: return KEY_X;
      5: return KEY_Y;
      6: return KEY_A;
      default: return KEY_B;
    endcase
  endfunction

  // Applies one item to the parser state and returns the report it should produce.
  function automatic rcsp_pkg::result_t parse_item(input logic kind, input logic [7:0] ch,
                                                   input logic [rcsp_pkg::CHAN_W-1:0] query,
                                                   input logic [7:0] mask);
    rcsp_pkg::result_t r;
    logic [VALUE_W-1:0] value;
    r = '0;
    if (kind == KIND_TICK) begin
      ticks_seen++;
      if (idle_ticks != 32'hFFFF_FFFF) idle_ticks++;
    end else begin
      chars_seen++;
      idle_ticks = '0;
      if (ch >= rcsp_pkg::CHAR_ZERO && ch <= rcsp_pkg::CHAR_NINE) begin
        number_acc = number_acc * 16'd10 + {8'd0, ch - rcsp_pkg::CHAR_ZERO};
      end else if (ch == rcsp_pkg::CHAR_MINUS) begin
        number_negative = 1'b1;
      end else begin
        value = number_negative ? (16'd0 - number_acc) : number_acc;
        for (int i = 0; i < rcsp_pkg::NUM_CHANNELS; i++) begin
          if (prev_letter == channel_letter(i)) begin
            channel_values[i] = value;
            r.channel_written = 1'b1;
            r.written_channel = rcsp_pkg::CHAN_W'(i);
            r.written_value = value[rcsp_pkg::OUT_W-1:0];
            stores_seen++;
          end
        end
        number_acc = '0;
        number_negative = 1'b0;
        if (ch == rcsp_pkg::CHAR_NEWLINE) begin
          buttons_committed = buttons_pending;
          buttons_pending = '0;
        end else begin
          for (int i = 0; i < 8; i++)
            if (ch == button_letter(i)) buttons_pending[i] = 1'b1;
        end
        prev_letter = ch;
      end
    end
    r.query_value = (query < rcsp_pkg::NUM_CHANNELS)
                    ? channel_values[query][rcsp_pkg::OUT_W-1:0] : '0;
    r.masked_buttons = buttons_committed & mask;
    r.timed_out = idle_ticks > timeout_limit;
    if (r.timed_out) timeouts_seen++;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : report_monitor
    rcsp_pkg::result_t got;
    rcsp_pkg::result_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.query_value     = m_axis_tdata[15:0];
        got.masked_buttons  = m_axis_tdata[23:16];
        got.timed_out       = m_axis_tdata[24];
        got.written_channel = m_axis_tdata[27:25];
        got.written_value   = m_axis_tdata[43:28];
        got.channel_written = m_axis_tuser;
        if (due_reports.size() == 0) begin
          error_count++;
          $display("%0t: unexpected report, tdata %h tuser %b", $time,
                   m_axis_tdata, m_axis_tuser);
        end else begin
          want = due_reports.pop_front();
          check_field("query_value", want.query_value, got.query_value);
          check_field("masked_buttons", want.masked_buttons, got.masked_buttons);
          check_field("timed_out", want.timed_out, got.timed_out);
          check_field("channel_written", want.channel_written, got.channel_written);
          check_field("written_channel", want.written_channel, got.written_channel);
          check_field("written_value", want.written_value, got.written_value);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        due_reports.push_back(parse_item(s_axis_tuser, s_axis_tdata[7:0],
                                         s_axis_tdata[10:8], s_axis_tdata[18:11]));
    end
  end

  // Receiver: short random stalls, and one long hold-off when a test asks for it.
  initial begin : report_receiver
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else if (receiver_stalls && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(7, 39);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (!sender_idles) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input logic kind, input logic [7:0] ch);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {5'd0, 8'($urandom_range(0, 255)), 3'($urandom_range(0, 7)), ch};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_digits(input longint unsigned value);
    string text;
    text = $sformatf("%0d", value);
    for (int i = 0; i < text.len(); i++) send_item(KIND_CHAR, text[i]);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_item(KIND_TICK, 8'($urandom_range(0, 255)));
  endtask

  // Waits for every outstanding report, then lets the pipeline settle.
  task automatic settle();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (due_reports.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (due_reports.size() != 0) begin
      error_count++;
      $display("%0t: timed out with %0d reports outstanding", $time, due_reports.size());
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_timeout(input logic [31:0] limit);
    cfg_we <= 1'b1;
    cfg_wdata <= limit;
    timeout_limit = limit;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A short idle run that stays below the timeout that applies after reset.
  task automatic test_reset_timeout();
    send_ticks(RESET_TICKS);
    send_item(KIND_CHAR, CHAR_HASH);
  endtask

  // Largest positive value, most negative value, the largest 16-bit value, and a field
  // ended after an unknown letter, which must store nothing.
  task automatic test_number_extremes();
    send_item(KIND_CHAR, LETTER_X);
    send_digits(32767);
    send_item(KIND_CHAR, LETTER_Y);
    send_item(KIND_CHAR, rcsp_pkg::CHAR_MINUS);
    send_digits(32768);
    send_item(KIND_CHAR, LETTER_A);
    send_digits(65535);
    send_item(KIND_CHAR, LETTER_Q);
    send_digits(7);
    send_item(KIND_CHAR, CHAR_HASH);
  endtask

  task automatic test_buttons();
    for (int i = 0; i < 8; i++) send_item(KIND_CHAR, button_letter(i));
    send_item(KIND_CHAR, rcsp_pkg::CHAR_NEWLINE);
    send_item(KIND_CHAR, rcsp_pkg::CHAR_NEWLINE);
  endtask

  task automatic test_timeout_extremes();
    settle();
    write_timeout(32'd0);
    send_ticks(1);
    send_item(KIND_CHAR, LETTER_Z);
    send_ticks(1);
    settle();
    write_timeout(32'hFFFF_FFFF);
    send_ticks(3);
    settle();
    write_timeout(32'd1);
    send_ticks(3);
  endtask

  // The receiver stops for a long stretch while items keep coming, so the
  // block fills up and has to hold off its input.
  task automatic test_backpressure();
    settle();
    sender_idles = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 60; i++)
      send_item(KIND_CHAR, channel_letter(i % rcsp_pkg::NUM_CHANNELS));
    sender_idles = 1'b1;
  endtask

  task automatic send_frame();
    int fields;
    int r;
    fields = $urandom_range(1, 4);
    repeat (fields) begin
      if ($urandom_range(0, 9) < 3) send_ticks($urandom_range(1, 15));
      if ($urandom_range(0, 3) == 0) send_item(KIND_CHAR, rcsp_pkg::CHAR_MINUS);
      r = $urandom_range(0, 99);
      if (r < 70) send_digits($urandom_range(0, 99999));
      else if (r < 85) send_digits($urandom);
      r = $urandom_range(0, 99);
      if (r < 50)
        send_item(KIND_CHAR,
                  channel_letter($urandom_range(0, rcsp_pkg::NUM_CHANNELS - 1)));
      else if (r < 85) send_item(KIND_CHAR, button_letter($urandom_range(0, 7)));
      else send_item(KIND_CHAR, 8'($urandom_range(0, 255)));
    end
    if ($urandom_range(0, 99) < 85) send_item(KIND_CHAR, rcsp_pkg::CHAR_NEWLINE);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(4, 10))
      send_item(logic'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_streams();
    int first;
    logic [31:0] limit;
    first = items_sent;
    while (items_sent - first < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 5))
        0: limit = 32'd0;
        1: limit = 32'hFFFF_FFFF;
        2: limit = $urandom;
        default: limit = $urandom_range(1, 12);
      endcase
      write_timeout(limit);
      sender_idles = $urandom_range(0, 3) != 0;
      receiver_stalls = $urandom_range(0, 3) != 0;
      repeat (8) begin
        if ($urandom_range(0, 4) != 0) send_frame();
        else send_noise();
      end
    end
    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    number_acc = '0;
    number_negative = 1'b0;
    prev_letter = '0;
    buttons_pending = '0;
    buttons_committed = '0;
    for (int i = 0; i < rcsp_pkg::NUM_CHANNELS; i++) channel_values[i] = '0;
    idle_ticks = '0;
    timeout_limit = rcsp_pkg::TIMEOUT_RESET;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_timeout();
    test_number_extremes();
    test_buttons();
    test_timeout_extremes();
    test_backpressure();
    test_random_streams();
    settle();

    $display("Sent %0d items: %0d characters and %0d ticks.", items_sent, chars_seen,
             ticks_seen);
    $display("Predicted %0d channel stores and %0d timed-out reports.", stores_seen,
             timeouts_seen);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
